>>> hdl/tiphc_pkg.sv
// Shared types and constants for the turn-in-place heading controller.
`timescale 1ns / 1ps

package tiphc_pkg;

  localparam int HEAD_W = 32;  // heading, delta and remaining ports
  localparam int TIME_W = 32;
  localparam int TOL_W  = 16;
  localparam int SPD_W  = 16;  // max_speed / min_speed registers
  localparam int BAND_W = 23;
  localparam int REQ_W  = 18;
  localparam int DRV_W  = 17;
  localparam int STAT_W = 3;
  localparam int CMD_W  = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // taper product |remaining| * |speed span| and its divider
  localparam int PROD_W = BAND_W + SPD_W;

  localparam logic [TOL_W-1:0]  TOL_RST     = 16'd256;
  localparam logic [TIME_W-1:0] TIMEOUT_RST = 32'd5000;
  localparam logic [SPD_W-1:0]  MAX_SPD_RST = 16'd32768;
  localparam logic [SPD_W-1:0]  MIN_SPD_RST = 16'd0;
  localparam logic [BAND_W-1:0] BAND_RST    = 23'd0;

  typedef enum logic [CMD_W-1:0] {
    CMD_BEGIN  = 2'd0,
    CMD_UPDATE = 2'd1,
    CMD_CANCEL = 2'd2,
    CMD_RESET  = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    PH_IDLE      = 3'd0,
    PH_RUNNING   = 3'd1,
    PH_SUCCEEDED = 3'd2,
    PH_TIMEDOUT  = 3'd3,
    PH_CANCELLED = 3'd4
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOLERANCE = 3'd0,
    CFG_TIMEOUT   = 3'd1,
    CFG_MAX_SPEED = 3'd2,
    CFG_MIN_SPEED = 3'd3,
    CFG_BAND      = 3'd4,
    CFG_TURN_SIGN = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [TOL_W-1:0]  tolerance;
    logic [TIME_W-1:0] timeout_ms;
    logic [SPD_W-1:0]  max_speed;
    logic [SPD_W-1:0]  min_speed;
    logic [BAND_W-1:0] slow_down_band;
    logic              turn_sign_negative;
  } cfg_t;

endpackage

>>> hdl/turn_in_place_heading_controller.sv
// Top level of the turn-in-place heading controller.
`timescale 1ns / 1ps

// Turn-in-place heading controller. Each input transaction carries a command
// (begin, update, cancel, reset) and produces exactly one result transaction
// with the status, the latest remaining angle and, where issued, opposite
// wheel commands. Begin, cancel and reset, and an update with no turn running,
// go straight to commit; other updates pass evaluation and, unless timed out,
// classification; one inside the slow-down band also the 39-step restoring
// taper divider (one quotient bit per cycle). Items are carried out
// one at a time by the back end; a two-entry queue in front of it keeps
// taking transactions while the back end works, and the result register
// lets the next item start while an earlier result waits to be taken.
// Configuration writes are always accepted (cfg_ready is tied high) and must
// only be made while no transaction is in flight; indexes beyond the
// register list are ignored.

module turn_in_place_heading_controller import tiphc_pkg::*; #(
  parameter int ANGLE_WIDTH     = 32,
  parameter int SPEED_FRAC_BITS = 15,
  parameter int QUEUE_DEPTH     = 2
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // configuration write channel
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  // command channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [CMD_W-1:0]         in_cmd,
  input  logic signed [HEAD_W-1:0] in_heading,
  input  logic signed [HEAD_W-1:0] in_delta,
  input  logic signed [REQ_W-1:0]  in_requested_speed,
  input  logic [TIME_W-1:0]        in_now_ms,
  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_finished,
  output logic [STAT_W-1:0]        out_status,
  output logic signed [HEAD_W-1:0] out_remaining,
  output logic                     out_drive_valid,
  output logic signed [DRV_W-1:0]  out_left_drive,
  output logic signed [DRV_W-1:0]  out_right_drive
);

  // queue entry: cmd, heading, now, begin target and remaining, success flag, speed
  localparam int ENTRY_W = CMD_W + HEAD_W + TIME_W + 2 * ANGLE_WIDTH + 1 +
                           SPEED_FRAC_BITS + 1;

  cfg_t               cfg_r, cfg_nxt;
  logic               q_push, q_full, q_pop, q_valid;
  logic [ENTRY_W-1:0] q_wdata, q_rdata;

  // -------------------------------------------------------------------------
  // Configuration registers
  // -------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TOLERANCE: cfg_nxt.tolerance          = cfg_data[TOL_W-1:0];
        CFG_TIMEOUT:   cfg_nxt.timeout_ms         = cfg_data[TIME_W-1:0];
        CFG_MAX_SPEED: cfg_nxt.max_speed          = cfg_data[SPD_W-1:0];
        CFG_MIN_SPEED: cfg_nxt.min_speed          = cfg_data[SPD_W-1:0];
        CFG_BAND:      cfg_nxt.slow_down_band     = cfg_data[BAND_W-1:0];
        CFG_TURN_SIGN: cfg_nxt.turn_sign_negative = cfg_data[0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tolerance          <= TOL_RST;
      cfg_r.timeout_ms         <= TIMEOUT_RST;
      cfg_r.max_speed          <= MAX_SPD_RST;
      cfg_r.min_speed          <= MIN_SPD_RST;
      cfg_r.slow_down_band     <= BAND_RST;
      cfg_r.turn_sign_negative <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // -------------------------------------------------------------------------
  // Front end: accept and classify, precompute begin values
  // -------------------------------------------------------------------------
  tiphc_front #(
    .ANGLE_WIDTH     (ANGLE_WIDTH),
    .SPEED_FRAC_BITS (SPEED_FRAC_BITS),
    .ENTRY_W         (ENTRY_W)
  ) u_front (
    .cfg                (cfg_r),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cmd             (in_cmd),
    .in_heading         (in_heading),
    .in_delta           (in_delta),
    .in_requested_speed (in_requested_speed),
    .in_now_ms          (in_now_ms),
    .q_full             (q_full),
    .q_push             (q_push),
    .q_data             (q_wdata)
  );

  // -------------------------------------------------------------------------
  // Decoupling queue
  // -------------------------------------------------------------------------
  tiphc_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_wdata),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_rdata)
  );

  // -------------------------------------------------------------------------
  // Back end: turn state, timeout / tolerance checks, taper, result register
  // -------------------------------------------------------------------------
  tiphc_back #(
    .ANGLE_WIDTH     (ANGLE_WIDTH),
    .SPEED_FRAC_BITS (SPEED_FRAC_BITS),
    .ENTRY_W         (ENTRY_W)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_valid         (q_valid),
    .q_data          (q_rdata),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_finished    (out_finished),
    .out_status      (out_status),
    .out_remaining   (out_remaining),
    .out_drive_valid (out_drive_valid),
    .out_left_drive  (out_left_drive),
    .out_right_drive (out_right_drive)
  );

endmodule

>>> hdl/tiphc_queue.sv
// Short FIFO between the classifying front end and the execution back end.
`timescale 1ns / 1ps

module tiphc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> hdl/tiphc_front.sv
// Front end: takes input transactions and precomputes the begin-command values.
`timescale 1ns / 1ps

module tiphc_front import tiphc_pkg::*; #(
  parameter int ANGLE_WIDTH     = 32,
  parameter int SPEED_FRAC_BITS = 15,
  parameter int ENTRY_W         = 8
) (
  input  cfg_t                     cfg,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [CMD_W-1:0]         in_cmd,
  input  logic signed [HEAD_W-1:0] in_heading,
  input  logic signed [HEAD_W-1:0] in_delta,
  input  logic signed [REQ_W-1:0]  in_requested_speed,
  input  logic [TIME_W-1:0]        in_now_ms,
  input  logic                     q_full,
  output logic                     q_push,
  output logic [ENTRY_W-1:0]       q_data
);

  localparam int AW  = ANGLE_WIDTH;
  localparam int SPW = SPEED_FRAC_BITS + 1;
  localparam int SW  = ((AW > HEAD_W) ? AW : HEAD_W) + 1;
  localparam int RW  = ((REQ_W > SPEED_FRAC_BITS + 2) ? REQ_W : SPEED_FRAC_BITS + 2) + 1;
  localparam logic [SW-1:0] A_HI = {{(SW - AW + 1){1'b0}}, {(AW - 1){1'b1}}};
  localparam logic [SW-1:0] A_LO = {{(SW - AW + 1){1'b1}}, {(AW - 1){1'b0}}};
  localparam logic [RW-1:0] FULL = RW'(1) << SPEED_FRAC_BITS;

  logic signed [SW-1:0]     head_x, delta_x, sum_x;
  logic [AW-1:0]            tgt, rem;
  logic [HEAD_W:0]          dext, dmag;
  logic                     succ;
  logic [RW-1:0]            req_x, req_c;
  logic [SPW-1:0]           spd;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    head_x  = {{(SW - HEAD_W){in_heading[HEAD_W-1]}}, in_heading};
    delta_x = {{(SW - HEAD_W){in_delta[HEAD_W-1]}}, in_delta};
    sum_x   = head_x + delta_x;

    // saturate heading + delta and delta itself to the angle width
    if (sum_x > $signed(A_HI)) begin
      tgt = A_HI[AW-1:0];
    end else if (sum_x < $signed(A_LO)) begin
      tgt = A_LO[AW-1:0];
    end else begin
      tgt = sum_x[AW-1:0];
    end
    if (delta_x > $signed(A_HI)) begin
      rem = A_HI[AW-1:0];
    end else if (delta_x < $signed(A_LO)) begin
      rem = A_LO[AW-1:0];
    end else begin
      rem = delta_x[AW-1:0];
    end

    dext = {in_delta[HEAD_W-1], in_delta};
    dmag = dext[HEAD_W] ? (~dext + (HEAD_W + 1)'(1)) : dext;
    succ = (dmag <= (HEAD_W + 1)'(cfg.tolerance));

    req_x = {{(RW - REQ_W){in_requested_speed[REQ_W-1]}}, in_requested_speed};
    if (req_x[RW-1]) begin
      req_c = '0;
    end else if (req_x > FULL) begin
      req_c = FULL;
    end else begin
      req_c = req_x;
    end
    spd = req_c[SPW-1:0];
  end

  // entry: cmd, heading, now, begin target, begin remaining, begin success, speed
  assign q_data = {in_cmd, in_heading, in_now_ms, tgt, rem, succ, spd};

endmodule

>>> hdl/tiphc_back.sv
// Back end: heading state, timeout and tolerance checks, taper divider, result register.
`timescale 1ns / 1ps

module tiphc_back import tiphc_pkg::*; #(
  parameter int ANGLE_WIDTH     = 32,
  parameter int SPEED_FRAC_BITS = 15,
  parameter int ENTRY_W         = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cfg_t                     cfg,
  input  logic                     q_valid,
  input  logic [ENTRY_W-1:0]       q_data,
  output logic                     q_pop,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_finished,
  output logic [STAT_W-1:0]        out_status,
  output logic signed [HEAD_W-1:0] out_remaining,
  output logic                     out_drive_valid,
  output logic signed [DRV_W-1:0]  out_left_drive,
  output logic signed [DRV_W-1:0]  out_right_drive
);

  localparam int AW    = ANGLE_WIDTH;
  localparam int SPW   = SPEED_FRAC_BITS + 1;
  localparam int SW    = ((AW > HEAD_W) ? AW : HEAD_W) + 1;
  localparam int CMPW  = (AW > BAND_W) ? AW : BAND_W;
  localparam int CW    = ((SPW > SPD_W) ? SPW : SPD_W) + 1;
  localparam int TW    = SPD_W + 2;
  localparam int CNT_W = $clog2(PROD_W);
  localparam logic [SW-1:0] A_HI = {{(SW - AW + 1){1'b0}}, {(AW - 1){1'b1}}};
  localparam logic [SW-1:0] A_LO = {{(SW - AW + 1){1'b1}}, {(AW - 1){1'b0}}};

  // entry field positions, LSB first
  localparam int SPD_LSB  = 0;
  localparam int SUCC_BIT = SPW;
  localparam int REM_LSB  = SUCC_BIT + 1;
  localparam int TGT_LSB  = REM_LSB + AW;
  localparam int NOW_LSB  = TGT_LSB + AW;
  localparam int HEAD_LSB = NOW_LSB + TIME_W;
  localparam int CMD_LSB  = HEAD_LSB + HEAD_W;

  typedef enum logic [2:0] {
    S_IDLE, S_EVAL, S_CLS, S_MUL, S_DIV, S_FIN, S_COMMIT
  } st_t;

  st_t                st_r, st_nxt;
  phase_t             phase_r, phase_nxt;
  logic [AW-1:0]      tgt_r, tgt_nxt;
  logic [AW-1:0]      rem_r, rem_nxt;
  logic [SPW-1:0]     spd_r, spd_nxt;
  logic [TIME_W-1:0]  start_r, start_nxt;

  logic [ENTRY_W-1:0] ent_r, ent_nxt;
  logic               run_r, run_nxt;
  logic               to_r, to_nxt;
  logic               ok_r, ok_nxt;
  logic               drv_r, drv_nxt;
  logic [AW-1:0]      remw_r, remw_nxt;
  logic [BAND_W-1:0]  amag_r, amag_nxt;
  logic [SPD_W-1:0]   dmag_r, dmag_nxt;
  logic [SPD_W-1:0]   s_r, s_nxt;
  logic               neg_r, neg_nxt;
  logic [PROD_W-1:0]  dvd_r, dvd_nxt;
  logic [BAND_W-1:0]  dr_r, dr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [SPD_W-1:0]   sp_r, sp_nxt;

  logic                     ov_r, ov_nxt;
  logic                     ofin_r, ofin_nxt;
  logic [STAT_W-1:0]        ostat_r, ostat_nxt;
  logic signed [HEAD_W-1:0] orem_r, orem_nxt;
  logic                     odv_r, odv_nxt;
  logic signed [DRV_W-1:0]  oleft_r, oleft_nxt;
  logic signed [DRV_W-1:0]  oright_r, oright_nxt;

  cmd_t                 e_cmd;
  logic [HEAD_W-1:0]    e_head;
  logic [TIME_W-1:0]    e_now;
  logic [AW-1:0]        e_tgt, e_rem;
  logic                 e_succ;
  logic [SPW-1:0]       e_spd;

  logic [TIME_W-1:0]    elapsed;
  logic signed [SW-1:0] diff;
  logic [AW-1:0]        amag;
  logic [CMPW-1:0]      a_x;
  logic [CW-1:0]        st_x, mx_x;
  logic [SPD_W-1:0]     s_c;
  logic [SPD_W:0]       span;
  logic [BAND_W:0]      trial;
  logic                 ge;
  logic signed [TW-1:0] t0, t1, t2, mn_x, s_x, q_x;
  logic [DRV_W-1:0]     w_mag, wheel;
  logic [SW-1:0]        rem_sx;

  assign e_cmd  = cmd_t'(ent_r[CMD_LSB +: CMD_W]);
  assign e_head = ent_r[HEAD_LSB +: HEAD_W];
  assign e_now  = ent_r[NOW_LSB +: TIME_W];
  assign e_tgt  = ent_r[TGT_LSB +: AW];
  assign e_rem  = ent_r[REM_LSB +: AW];
  assign e_succ = ent_r[SUCC_BIT];
  assign e_spd  = ent_r[SPD_LSB +: SPW];

  assign out_valid       = ov_r;
  assign out_finished    = ofin_r;
  assign out_status      = ostat_r;
  assign out_remaining   = orem_r;
  assign out_drive_valid = odv_r;
  assign out_left_drive  = oleft_r;
  assign out_right_drive = oright_r;

  always_comb begin
    st_nxt     = st_r;
    phase_nxt  = phase_r;
    tgt_nxt    = tgt_r;
    rem_nxt    = rem_r;
    spd_nxt    = spd_r;
    start_nxt  = start_r;
    ent_nxt    = ent_r;
    run_nxt    = run_r;
    to_nxt     = to_r;
    ok_nxt     = ok_r;
    drv_nxt    = drv_r;
    remw_nxt   = remw_r;
    amag_nxt   = amag_r;
    dmag_nxt   = dmag_r;
    s_nxt      = s_r;
    neg_nxt    = neg_r;
    dvd_nxt    = dvd_r;
    dr_nxt     = dr_r;
    cnt_nxt    = cnt_r;
    sp_nxt     = sp_r;
    ov_nxt     = ov_r && out_stall;
    ofin_nxt   = ofin_r;
    ostat_nxt  = ostat_r;
    orem_nxt   = orem_r;
    odv_nxt    = odv_r;
    oleft_nxt  = oleft_r;
    oright_nxt = oright_r;
    q_pop      = 1'b0;

    elapsed = e_now - start_r;
    diff    = {{(SW - AW){tgt_r[AW-1]}}, tgt_r} - {{(SW - HEAD_W){e_head[HEAD_W-1]}}, e_head};
    amag    = remw_r[AW-1] ? (~remw_r + AW'(1)) : remw_r;
    a_x     = CMPW'(amag);
    st_x    = CW'(spd_r);
    mx_x    = CW'(cfg.max_speed);
    s_c     = (st_x < mx_x) ? st_x[SPD_W-1:0] : cfg.max_speed;
    span    = {1'b0, s_c} - {1'b0, cfg.min_speed};
    trial   = {dr_r, dvd_r[PROD_W-1]};
    ge      = (trial >= {1'b0, cfg.slow_down_band});
    mn_x    = TW'(cfg.min_speed);
    s_x     = TW'(s_r);
    q_x     = TW'(dvd_r[SPD_W-1:0]);
    t0      = neg_r ? (mn_x - q_x) : (mn_x + q_x);
    t1      = t0[TW-1] ? '0 : t0;
    t2      = (t1 < mn_x) ? ((mn_x > s_x) ? s_x : mn_x) : ((t1 > s_x) ? s_x : t1);
    w_mag   = {1'b0, sp_r};
    wheel   = (remw_r[AW-1] ^ cfg.turn_sign_negative) ? (~w_mag + DRV_W'(1)) : w_mag;
    rem_sx  = '0;

    case (st_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          ent_nxt = q_data;
          run_nxt = (cmd_t'(q_data[CMD_LSB +: CMD_W]) == CMD_UPDATE) &&
                    (phase_r == PH_RUNNING);
          to_nxt  = 1'b0;
          ok_nxt  = 1'b0;
          drv_nxt = 1'b0;
          st_nxt  = run_nxt ? S_EVAL : S_COMMIT;
        end
      end
      S_EVAL: begin
        to_nxt = (elapsed >= cfg.timeout_ms);
        if (diff > $signed(A_HI)) begin
          remw_nxt = A_HI[AW-1:0];
        end else if (diff < $signed(A_LO)) begin
          remw_nxt = A_LO[AW-1:0];
        end else begin
          remw_nxt = diff[AW-1:0];
        end
        st_nxt = to_nxt ? S_COMMIT : S_CLS;
      end
      S_CLS: begin
        s_nxt    = s_c;
        amag_nxt = a_x[BAND_W-1:0];
        neg_nxt  = span[SPD_W];
        dmag_nxt = span[SPD_W] ? (~span[SPD_W-1:0] + SPD_W'(1)) : span[SPD_W-1:0];
        if (a_x <= CMPW'(cfg.tolerance)) begin
          ok_nxt = 1'b1;
          st_nxt = S_COMMIT;
        end else begin
          drv_nxt = 1'b1;
          if ((cfg.slow_down_band == '0) || (a_x >= CMPW'(cfg.slow_down_band))) begin
            sp_nxt = s_c;
            st_nxt = S_COMMIT;
          end else begin
            st_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        dvd_nxt = PROD_W'(amag_r) * PROD_W'(dmag_r);
        dr_nxt  = '0;
        cnt_nxt = '0;
        st_nxt  = S_DIV;
      end
      S_DIV: begin
        // restoring division, one quotient bit a cycle
        dr_nxt  = ge ? BAND_W'(trial - {1'b0, cfg.slow_down_band}) : trial[BAND_W-1:0];
        dvd_nxt = {dvd_r[PROD_W-2:0], ge};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(PROD_W - 1)) begin
          st_nxt = S_FIN;
        end
      end
      S_FIN: begin
        sp_nxt = t2[SPD_W-1:0];
        st_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (!ov_r || !out_stall) begin
          odv_nxt    = 1'b1;
          oleft_nxt  = '0;
          oright_nxt = '0;
          case (e_cmd)
            CMD_BEGIN: begin
              phase_nxt = e_succ ? PH_SUCCEEDED : PH_RUNNING;
              tgt_nxt   = e_tgt;
              rem_nxt   = e_rem;
              spd_nxt   = e_spd;
              start_nxt = e_now;
            end
            CMD_UPDATE: begin
              if (!run_r) begin
                odv_nxt = 1'b0;
              end else if (to_r) begin
                phase_nxt = PH_TIMEDOUT;
              end else begin
                rem_nxt = remw_r;
                if (ok_r) begin
                  phase_nxt = PH_SUCCEEDED;
                end else if (drv_r) begin
                  oleft_nxt  = wheel;
                  oright_nxt = ~wheel + DRV_W'(1);
                end
              end
            end
            CMD_CANCEL: begin
              phase_nxt = PH_CANCELLED;
            end
            CMD_RESET: begin
              phase_nxt = PH_IDLE;
              tgt_nxt   = '0;
              rem_nxt   = '0;
              spd_nxt   = '0;
              start_nxt = '0;
            end
            default: begin
              phase_nxt = phase_r;
            end
          endcase
          rem_sx    = {{(SW - AW){rem_nxt[AW-1]}}, rem_nxt};
          ov_nxt    = 1'b1;
          ofin_nxt  = (phase_nxt != PH_RUNNING);
          ostat_nxt = phase_nxt;
          orem_nxt  = rem_sx[HEAD_W-1:0];
          st_nxt    = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      phase_r <= PH_IDLE;
      tgt_r   <= '0;
      rem_r   <= '0;
      spd_r   <= '0;
      start_r <= '0;
      ov_r    <= 1'b0;
      cnt_r   <= '0;
    end else begin
      st_r    <= st_nxt;
      phase_r <= phase_nxt;
      tgt_r   <= tgt_nxt;
      rem_r   <= rem_nxt;
      spd_r   <= spd_nxt;
      start_r <= start_nxt;
      ov_r    <= ov_nxt;
      cnt_r   <= cnt_nxt;
    end
    ent_r    <= ent_nxt;
    run_r    <= run_nxt;
    to_r     <= to_nxt;
    ok_r     <= ok_nxt;
    drv_r    <= drv_nxt;
    remw_r   <= remw_nxt;
    amag_r   <= amag_nxt;
    dmag_r   <= dmag_nxt;
    s_r      <= s_nxt;
    neg_r    <= neg_nxt;
    dvd_r    <= dvd_nxt;
    dr_r     <= dr_nxt;
    sp_r     <= sp_nxt;
    ofin_r   <= ofin_nxt;
    ostat_r  <= ostat_nxt;
    orem_r   <= orem_nxt;
    odv_r    <= odv_nxt;
    oleft_r  <= oleft_nxt;
    oright_r <= oright_nxt;
  end

endmodule
